// ===== src/rotation_matrix_to_quaternion_top_assert.svh =====
// Assertion macros for the rotation matrix to quaternion block.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH

// Implication in the same cycle, masked during reset.
`define RMQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on every edge, reset included.
`define RMQ_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/rmq_pkg.sv =====
// Shared types and codes for the rotation matrix to quaternion block.
// No dependencies.
`timescale 1ns / 1ps

package rmq_pkg;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;
  localparam int LANE_W = 3;

  localparam int QBITS = 31;

  // numerators travel alongside the root chain, 33-bit two's complement each
  typedef struct packed {
    logic             valid;
    logic [1:0]       branch;
    logic [3:0][32:0] num;
  } rmq_side_t;

  // control carried alongside the divider chain
  typedef struct packed {
    logic        valid;
    logic [1:0]  branch;
    logic        degen;
    logic [31:0] half;
    logic [3:0]  neg;
    logic [3:0]  ovf;
  } rmq_ctl_t;

endpackage

// ===== src/rmq_front.sv =====
// Front stage: trace test, branch choice, root argument and numerators.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_front #(
  parameter int FRAC_BITS = 30,
  parameter int RW        = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [8:0][31:0]      mat,
  input  logic [29:0]           eps,
  output rmq_pkg::rmq_side_t    side,
  output logic [2*RW-1:0]       rad
);
  import rmq_pkg::*;

  localparam logic signed [34:0] ONE = 35'sd1 <<< FRAC_BITS;

  logic signed [34:0] a [9];
  logic signed [34:0] t, arg;
  logic [33:0]        argc;
  logic [1:0]         br;
  logic signed [32:0] b [9];
  logic [3:0][32:0]   num;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      a[i] = 35'(signed'(mat[i]));
      b[i] = 33'(signed'(mat[i]));
    end
    t   = a[0] + a[4] + a[8] + ONE;
    num = '0;
    if (t > $signed({5'd0, eps})) begin
      br  = BR_TRACE;
      arg = t;
      num[LANE_X] = b[7] - b[5];
      num[LANE_Y] = b[2] - b[6];
      num[LANE_Z] = b[3] - b[1];
    end else if ((a[4] >= a[0]) || (a[8] >= a[0])) begin
      if (a[8] >= a[4]) begin
        br  = BR_Z;
        arg = a[8] + ONE - a[0] - a[4];
        num[LANE_X] = b[2] + b[6];
        num[LANE_Y] = b[5] + b[7];
        num[LANE_W] = b[1] - b[3];
      end else begin
        br  = BR_Y;
        arg = a[4] + ONE - a[0] - a[8];
        num[LANE_X] = b[1] + b[3];
        num[LANE_Z] = b[5] + b[7];
        num[LANE_W] = b[2] - b[6];
      end
    end else begin
      br  = BR_X;
      arg = a[0] + ONE - a[4] - a[8];
      num[LANE_Y] = b[1] + b[3];
      num[LANE_Z] = b[2] + b[6];
      num[LANE_W] = b[5] - b[7];
    end
    // negative argument clamps to zero
    argc = arg[34] ? 34'd0 : arg[33:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side.valid <= in_valid;
    end
    if (en) begin
      side.branch <= br;
      side.num    <= num;
      rad         <= {{(2*RW-34){1'b0}}, argc} << FRAC_BITS;
    end
  end

endmodule

// ===== src/rmq_sqrt_cell.sv =====
// One root bit of the digit-by-digit square root, numerators ride along.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_sqrt_cell #(
  parameter int RW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  rmq_pkg::rmq_side_t side_in,
  input  logic [RW+1:0]      rem_in,
  input  logic [RW-1:0]      root_in,
  input  logic [2*RW-1:0]    rad_in,
  output rmq_pkg::rmq_side_t side_out,
  output logic [RW+1:0]      rem_out,
  output logic [RW-1:0]      root_out,
  output logic [2*RW-1:0]    rad_out
);
  import rmq_pkg::*;

  logic [RW+3:0] rem2, trial, diff;
  logic          ge;

  always_comb begin
    rem2  = {rem_in, rad_in[2*RW-1 -: 2]};
    trial = {2'b00, root_in, 2'b01};
    ge    = rem2 >= trial;
    diff  = rem2 - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out.valid <= side_in.valid;
    end
    if (en) begin
      side_out.branch <= side_in.branch;
      side_out.num    <= side_in.num;
      rem_out         <= ge ? diff[RW+1:0] : rem2[RW+1:0];
      root_out        <= {root_in[RW-2:0], ge};
      rad_out         <= rad_in << 2;
    end
  end

endmodule

// ===== src/rmq_div_cell.sv =====
// One quotient bit of four restoring dividers sharing a divisor.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_div_cell #(
  parameter int RW = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rmq_pkg::rmq_ctl_t ctl_in,
  input  logic [RW:0]       den_in,
  input  logic [3:0][RW:0]  rem_in,
  input  logic [3:0][30:0]  low_in,
  input  logic [3:0][30:0]  quo_in,
  output rmq_pkg::rmq_ctl_t ctl_out,
  output logic [RW:0]       den_out,
  output logic [3:0][RW:0]  rem_out,
  output logic [3:0][30:0]  low_out,
  output logic [3:0][30:0]  quo_out
);
  import rmq_pkg::*;

  logic [3:0][RW+1:0] r2;
  logic [3:0][RW+1:0] dif;
  logic [3:0]         ge;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r2[k]  = {rem_in[k], low_in[k][30]};
      ge[k]  = r2[k] >= {1'b0, den_in};
      dif[k] = r2[k] - {1'b0, den_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.branch <= ctl_in.branch;
      ctl_out.degen  <= ctl_in.degen;
      ctl_out.half   <= ctl_in.half;
      ctl_out.neg    <= ctl_in.neg;
      ctl_out.ovf    <= ctl_in.ovf;
      den_out        <= den_in;
      for (int k = 0; k < 4; k++) begin
        rem_out[k] <= ge[k] ? dif[k][RW:0] : r2[k][RW:0];
        low_out[k] <= {low_in[k][29:0], 1'b0};
        quo_out[k] <= {quo_in[k][29:0], ge[k]};
      end
    end
  end

endmodule

// ===== src/rotation_matrix_to_quaternion_top.sv =====
// Rotation matrix to quaternion, top level: front stage, root chain, divider chain.
// Depends on rmq_pkg, rmq_front, rmq_sqrt_cell, rmq_div_cell and the assert header.
//
// Use:
//  - s_* channel: one request carries a 3x3 matrix, nine signed fixed-point entries.
//  - m_* channel: one request per matrix, quaternion x,y,z,w plus branch and
//    degenerate flag in m_tuser.
//  - cfg_* channel: writes the trace threshold; always ready, write only while idle.
//  - Throughput: one matrix per cycle while the output is not stalled. Every stage
//    is a cell of a fixed chain, so nothing loops back.
//  - Pipeline: RW + 34 register stages, where RW = (FRAC_BITS+35)/2 root cells.
//    Stages: 1 front stage, RW root cells, 1 divider set-up stage,
//    31 quotient cells, 1 output register.
//  - Stall: the whole chain advances only when the output register is empty
//    or being taken; s_tready drops with it, so no request is lost.
//  - Reset: clears every valid bit in the chain and the output register, and
//    loads the threshold with its reset value.
//  - A zero root gives a zero quaternion with degenerate set.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_top_assert.svh"

module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = 30
) (
  input  logic         clk,
  input  logic         rst,
  // m00,m01,m02,m10,m11,m12,m20,m21,m22, 32 bits each from bit 0 up
  input  logic [287:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // quat_x,quat_y,quat_z,quat_w, 32 bits each from bit 0 up
  output logic [127:0] m_tdata,
  // branch_taken [1:0], degenerate [2]
  output logic [2:0]   m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic [29:0]  cfg_data,
  input  logic         cfg_valid,
  output logic         cfg_ready
);
  import rmq_pkg::*;

  localparam int RW   = (FRAC_BITS + 35) / 2;   // root bits
  localparam int DW   = RW + 1;                 // divisor bits, 2*root
  localparam int NW   = 33 + FRAC_BITS;         // scaled dividend bits
  localparam int HW   = NW - QBITS;             // dividend bits above the quotient
  localparam int CMPW = (HW > DW) ? HW : DW;

  logic        en;
  logic [29:0] trace_eps;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_eps <= 30'd1074;
    end else if (cfg_valid) begin
      trace_eps <= cfg_data;
    end
  end

  // front stage
  rmq_side_t        sq_side [RW+1];
  logic [RW+1:0]    sq_rem  [RW+1];
  logic [RW-1:0]    sq_root [RW+1];
  logic [2*RW-1:0]  sq_rad  [RW+1];

  rmq_front #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .mat      (s_tdata),
    .eps      (trace_eps),
    .side     (sq_side[0]),
    .rad      (sq_rad[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  // root chain, one bit per cell
  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    rmq_sqrt_cell #(.RW(RW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .side_in  (sq_side[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .rad_in   (sq_rad[i]),
      .side_out (sq_side[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1]),
      .rad_out  (sq_rad[i+1])
    );
  end

  // divider set-up: magnitudes, overflow test, first partial remainder
  rmq_ctl_t          dv_ctl [QBITS+1];
  logic [DW-1:0]     dv_den [QBITS+1];
  logic [3:0][DW-1:0] dv_rem [QBITS+1];
  logic [3:0][30:0]  dv_low [QBITS+1];
  logic [3:0][30:0]  dv_quo [QBITS+1];

  logic [RW-1:0]      root;
  logic [DW-1:0]      den;
  logic [3:0]         neg, ovf;
  logic [3:0][32:0]   mag;
  logic [3:0][NW-1:0] nsc;
  logic [3:0][CMPW-1:0] high;
  logic [3:0][DW-1:0] rem0;
  logic [3:0][30:0]   low0;

  always_comb begin
    root = sq_root[RW];
    den  = {root, 1'b0};
    for (int k = 0; k < 4; k++) begin
      neg[k]  = sq_side[RW].num[k][32];
      mag[k]  = neg[k] ? (33'd0 - sq_side[RW].num[k]) : sq_side[RW].num[k];
      nsc[k]  = {mag[k], {FRAC_BITS{1'b0}}};
      high[k] = CMPW'(nsc[k][NW-1:QBITS]);
      ovf[k]  = high[k] >= CMPW'(den);
      rem0[k] = ovf[k] ? '0 : high[k][DW-1:0];
      low0[k] = nsc[k][QBITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0].valid <= 1'b0;
    end else if (en) begin
      dv_ctl[0].valid <= sq_side[RW].valid;
    end
    if (en) begin
      dv_ctl[0].branch <= sq_side[RW].branch;
      dv_ctl[0].degen  <= (root == '0);
      dv_ctl[0].half   <= 32'(root >> 1);
      dv_ctl[0].neg    <= neg;
      dv_ctl[0].ovf    <= ovf;
      dv_den[0]        <= den;
      dv_rem[0]        <= rem0;
      dv_low[0]        <= low0;
      dv_quo[0]        <= '0;
    end
  end

  // quotient chain, one bit per cell for all four lanes
  for (genvar j = 0; j < QBITS; j++) begin : g_div
    rmq_div_cell #(.RW(RW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (dv_ctl[j]),
      .den_in  (dv_den[j]),
      .rem_in  (dv_rem[j]),
      .low_in  (dv_low[j]),
      .quo_in  (dv_quo[j]),
      .ctl_out (dv_ctl[j+1]),
      .den_out (dv_den[j+1]),
      .rem_out (dv_rem[j+1]),
      .low_out (dv_low[j+1]),
      .quo_out (dv_quo[j+1])
    );
  end

  // output assembly: half-root lane, saturation, degenerate zeroing
  rmq_ctl_t          fin;
  logic [3:0][31:0]  comp;
  int                half_lane;

  always_comb begin
    fin = dv_ctl[QBITS];
    case (fin.branch)
      BR_TRACE: half_lane = LANE_W;
      BR_X:     half_lane = LANE_X;
      BR_Y:     half_lane = LANE_Y;
      BR_Z:     half_lane = LANE_Z;
      default:  half_lane = LANE_W;
    endcase
    for (int k = 0; k < 4; k++) begin
      if (fin.degen) begin
        comp[k] = '0;
      end else if (k == half_lane) begin
        comp[k] = fin.half;
      end else if (fin.ovf[k]) begin
        comp[k] = fin.neg[k] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        comp[k] = fin.neg[k] ? (32'd0 - {1'b0, dv_quo[QBITS][k]}) : {1'b0, dv_quo[QBITS][k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= fin.valid;
    end
    if (en) begin
      m_tdata <= comp;
      m_tuser <= {fin.degen, fin.branch};
    end
  end

  `RMQ_ASSERT_SAME(a_degen_zero, m_tvalid && m_tuser[2], m_tdata == 128'd0, "degenerate with nonzero quaternion")
  `RMQ_ASSERT_SAME(a_ready_rule, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready out of step with output")
  `RMQ_ASSERT_ALWAYS(a_reset_idle, $past(rst) && !rst, !m_tvalid, "output valid straight after reset")

endmodule
